### src/hfa_pkg.sv
// Shared types and constants of the hygienic fork arbiter. Depends on nothing;
// used by hfa_update, hygienic_fork_arbiter, fork_grant_checker and tb.
package hfa_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_USE  = 2'd2;

  localparam logic REQ_TAKE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [4:0] RING_SIZE_RESET = 5'd16;

  // One memory entry: phase of requester k and the state of fork k.
  typedef struct packed {
    logic [1:0] phase;
    logic       upper;      // fork owned by requester k (else by k-1)
    logic       dirty;
    logic       requested;
  } entry_t;

  typedef struct packed {
    entry_t ent_a;          // requester entry, left fork
    entry_t ent_b;          // right fork entry
    logic   status;         // 1 = item ignored
  } upd_t;

  function automatic entry_t reset_entry(input logic is_fork0);
    entry_t e;
    e.phase     = PH_IDLE;
    e.upper     = is_fork0;
    e.dirty     = 1'b1;
    e.requested = 1'b0;
    return e;
  endfunction

endpackage

### src/hygienic_fork_arbiter.sv
// Hygienic fork arbiter top level: sequencer, ring size register, output register.
// Depends on hfa_pkg, hfa_ram and hfa_update.
//
// For a requester inside the ring, the item passes through S_CALC, S_WRB and
// S_OUT after it is accepted. The read of the requester entry and the right
// fork entry is issued at acceptance. S_CALC updates and writes back the
// requester entry. S_WRB writes back the right fork entry. S_OUT hands the
// result to the output register. The input stalls until S_OUT is left, so
// the next item is accepted only after that. The single write port of the
// state memory keeps the two write-backs in separate states. For a requester
// beyond the ring, acceptance goes straight to S_OUT. The next item is
// accepted while a finished result still waits in the output register. A
// stalled output only holds the block in its last step. Entries that were
// never written read as their reset state through per-entry valid bits, so no
// clearing pass runs.
module hygienic_fork_arbiter #(
  parameter int MAX_REQUESTERS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [3:0] requester_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] phase_o,
  output logic       holds_left_o,
  output logic       holds_right_o,
  output logic       status_o
);

  localparam int AW = $clog2(MAX_REQUESTERS);
  localparam int CW = (AW > 5) ? AW + 1 : 6;
  localparam int EW = $bits(hfa_pkg::entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WRB  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [4:0]    ring_q;
  logic [MAX_REQUESTERS-1:0] valid_q, valid_d;

  logic          kind_q;
  logic [AW-1:0] lf_q, rf_q;
  hfa_pkg::entry_t ent_b_q;

  logic [1:0]    res_phase_q, res_phase_d;
  logic          res_left_q, res_left_d;
  logic          res_right_q, res_right_d;
  logic          res_status_q, res_status_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    phase_q;
  logic          holds_left_q, holds_right_q, status_q;

  logic [CW-1:0] ring_n;
  logic [CW-1:0] r_ext, r_inc, rf_ext;
  logic          beyond;
  logic          accept;
  logic          push;

  logic [EW-1:0] rdata_a, rdata_b;
  hfa_pkg::entry_t ent_a, ent_b;
  hfa_pkg::upd_t   upd;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  // ring size in use, clamped to 2..MAX_REQUESTERS
  always_comb begin
    ring_n = CW'(ring_q);
    if (ring_n < CW'(2)) begin
      ring_n = CW'(2);
    end else if (ring_n > CW'(MAX_REQUESTERS)) begin
      ring_n = CW'(MAX_REQUESTERS);
    end
  end

  assign r_ext  = CW'(requester_i);
  assign r_inc  = r_ext + CW'(1);
  assign rf_ext = (r_inc == ring_n) ? '0 : r_inc;
  assign beyond = (r_ext >= ring_n);

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign push        = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  hfa_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_REQUESTERS)
  ) u_state_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(r_ext[AW-1:0]),
    .raddr_b_i(rf_ext[AW-1:0]),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // entries never written read as their reset value
  assign ent_a = valid_q[lf_q] ? hfa_pkg::entry_t'(rdata_a)
                               : hfa_pkg::reset_entry(lf_q == '0);
  assign ent_b = valid_q[rf_q] ? hfa_pkg::entry_t'(rdata_b)
                               : hfa_pkg::reset_entry(rf_q == '0);

  hfa_update u_update (
    .req_type_i(kind_q),
    .ent_a_i   (ent_a),
    .ent_b_i   (ent_b),
    .upd_o     (upd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = lf_q;
    wdata = EW'(upd.ent_a);
    case (state_q)
      S_CALC: begin
        we    = 1'b1;
      end
      S_WRB: begin
        we    = 1'b1;
        waddr = rf_q;
        wdata = EW'(ent_b_q);
      end
      default: begin
        we    = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    res_phase_d  = res_phase_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    res_status_d = res_status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (beyond) begin
            res_phase_d  = hfa_pkg::PH_IDLE;
            res_left_d   = 1'b0;
            res_right_d  = 1'b0;
            res_status_d = 1'b1;
            state_d      = S_OUT;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        valid_d[lf_q] = 1'b1;
        res_phase_d   = upd.ent_a.phase;
        res_left_d    = upd.ent_a.upper;
        res_right_d   = !upd.ent_b.upper;
        res_status_d  = upd.status;
        state_d       = S_WRB;
      end
      S_WRB: begin
        valid_d[rf_q] = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_q      <= hfa_pkg::RING_SIZE_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ring_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_type_i;
      lf_q   <= r_ext[AW-1:0];
      rf_q   <= rf_ext[AW-1:0];
    end
    if (state_q == S_CALC) begin
      ent_b_q <= upd.ent_b;
    end
    res_phase_q  <= res_phase_d;
    res_left_q   <= res_left_d;
    res_right_q  <= res_right_d;
    res_status_q <= res_status_d;
    if (push) begin
      phase_q       <= res_phase_q;
      holds_left_q  <= res_left_q;
      holds_right_q <= res_right_q;
      status_q      <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phase_o       = phase_q;
  assign holds_left_o  = holds_left_q;
  assign holds_right_o = holds_right_q;
  assign status_o      = status_q;

endmodule

### src/hfa_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module hfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### src/hfa_update.sv
// Fork token update rules for one take or release item.
// Depends on hfa_pkg.
module hfa_update (
  input  logic            req_type_i,
  input  hfa_pkg::entry_t ent_a_i,
  input  hfa_pkg::entry_t ent_b_i,
  output hfa_pkg::upd_t   upd_o
);

  hfa_pkg::entry_t a;
  hfa_pkg::entry_t b;
  logic            got_l;
  logic            got_r;
  logic            status;

  always_comb begin
    a      = ent_a_i;
    b      = ent_b_i;
    got_l  = 1'b0;
    got_r  = 1'b0;
    status = 1'b0;
    if (req_type_i == hfa_pkg::REQ_TAKE) begin
      if (ent_a_i.phase == hfa_pkg::PH_USE) begin
        status = 1'b1;
      end else begin
        // left fork: requester owns it when upper is set
        if (a.upper) begin
          got_l = 1'b1;
        end else if (a.dirty) begin
          a.upper = 1'b1;
          a.dirty = 1'b0;
          got_l   = 1'b1;
        end else begin
          a.requested = 1'b1;
        end
        // right fork: requester owns it when upper is clear
        if (!b.upper) begin
          got_r = 1'b1;
        end else if (b.dirty) begin
          b.upper = 1'b0;
          b.dirty = 1'b0;
          got_r   = 1'b1;
        end else begin
          b.requested = 1'b1;
        end
        if (got_l && got_r) begin
          a.dirty = 1'b0;
          b.dirty = 1'b0;
          a.phase = hfa_pkg::PH_USE;
        end else begin
          a.phase = hfa_pkg::PH_WAIT;
        end
      end
    end else begin
      if (ent_a_i.phase != hfa_pkg::PH_USE) begin
        status = 1'b1;
      end else begin
        // dirty both, hand requested forks clean to the neighbor
        a.dirty = 1'b1;
        if (a.requested) begin
          a.requested = 1'b0;
          a.upper     = 1'b0;
          a.dirty     = 1'b0;
        end
        b.dirty = 1'b1;
        if (b.requested) begin
          b.requested = 1'b0;
          b.upper     = 1'b1;
          b.dirty     = 1'b0;
        end
        a.phase = hfa_pkg::PH_IDLE;
      end
    end
    upd_o.ent_a  = a;
    upd_o.ent_b  = b;
    upd_o.status = status;
  end

endmodule

### verif/fork_grant_checker.sv
// Checker for the hygienic fork arbiter: mirrors fork ownership, predicts each grant
// and compares it with the output channel. Depends on hfa_pkg for phase and request codes.
`timescale 1ns / 1ps

module fork_grant_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       req_type_i,
  input  logic [3:0] requester_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] phase_i,
  input  logic       holds_left_i,
  input  logic       holds_right_i,
  input  logic       status_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int SEATS = 16;

  typedef struct packed {
    logic [1:0] phase;
    logic       holds_left;
    logic       holds_right;
    logic       status;
  } grant_t;

  logic [1:0] seat_phase [SEATS];
  logic       fork_upper [SEATS];
  logic       fork_dirty [SEATS];
  logic       fork_wanted [SEATS];
  logic [4:0] ring_reg;
  grant_t     expected_grants [$];

  // Get fork k, or mark it wanted when the neighbour holds it clean.
  function automatic logic claim_fork(input int k, input logic mine);
    if (fork_upper[k] == mine) return 1'b1;
    if (fork_dirty[k]) begin
      fork_upper[k] = mine;
      fork_dirty[k] = 1'b0;
      return 1'b1;
    end
    fork_wanted[k] = 1'b1;
    return 1'b0;
  endfunction

  // Dirty fork k; pass it on clean if the neighbour asked for it.
  function automatic void hand_back(input int k, input logic other);
    fork_dirty[k] = 1'b1;
    if (fork_wanted[k]) begin
      fork_wanted[k] = 1'b0;
      fork_upper[k]  = other;
      fork_dirty[k]  = 1'b0;
    end
  endfunction

  function automatic grant_t arbitrate(input logic kind, input logic [3:0] who);
    grant_t g;
    int     n;
    int     lf;
    int     rf;
    logic   got_l;
    logic   got_r;
    n = int'(ring_reg);
    if (n < 2) n = 2;
    if (n > SEATS) n = SEATS;
    g = '0;
    if (int'(who) >= n) begin
      g.status = 1'b1;
      return g;
    end
    lf = int'(who);
    rf = (int'(who) + 1) % n;
    if (kind == hfa_pkg::REQ_TAKE) begin
      if (seat_phase[who] == hfa_pkg::PH_USE) begin
        g.status = 1'b1;
      end else begin
        got_l = claim_fork(lf, 1'b1);
        got_r = claim_fork(rf, 1'b0);
        if (got_l && got_r) begin
          fork_dirty[lf]  = 1'b0;
          fork_dirty[rf]  = 1'b0;
          seat_phase[who] = hfa_pkg::PH_USE;
        end else begin
          seat_phase[who] = hfa_pkg::PH_WAIT;
        end
      end
    end else if (seat_phase[who] != hfa_pkg::PH_USE) begin
      g.status = 1'b1;
    end else begin
      hand_back(lf, 1'b0);
      hand_back(rf, 1'b1);
      seat_phase[who] = hfa_pkg::PH_IDLE;
    end
    g.phase       = seat_phase[who];
    g.holds_left  = fork_upper[lf];
    g.holds_right = !fork_upper[rf];
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      for (int k = 0; k < SEATS; k++) begin
        seat_phase[k]  = hfa_pkg::PH_IDLE;
        fork_upper[k]  = (k == 0);
        fork_dirty[k]  = 1'b1;
        fork_wanted[k] = 1'b0;
      end
      ring_reg = hfa_pkg::RING_SIZE_RESET;
      expected_grants.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{phase_i, holds_left_i, holds_right_i, status_i};
        if (expected_grants.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected item phase %0d left %0b right %0b status %0b",
                     $realtime, seen.phase, seen.holds_left, seen.holds_right,
                     seen.status);
        end else begin
          want = expected_grants.pop_front();
          if (seen.phase !== want.phase || seen.holds_left !== want.holds_left ||
              seen.holds_right !== want.holds_right || seen.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: mismatch expected phase %0d left %0b right %0b status %0b,",
                        " got phase %0d left %0b right %0b status %0b"},
                       $realtime, want.phase, want.holds_left, want.holds_right,
                       want.status, seen.phase, seen.holds_left, seen.holds_right,
                       seen.status);
          end
        end
      end
      // an item accepted at this edge still sees the old ring size
      if (in_valid_i && !in_stall_i)
        expected_grants.push_back(arbitrate(req_type_i, requester_i));
      if (cfg_valid_i && cfg_ready_i) ring_reg = cfg_data_i;
      pending_o = expected_grants.size();
    end
  end

endmodule

### verif/tb.sv
// Hygienic fork arbiter testbench top: clock, reset, ring size writes, requests
// with random idling. Depends on hfa_pkg, the DUT and fork_grant_checker.
`timescale 1ns / 1ps

module tb;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       req_type_i;
  logic [3:0] requester_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] phase_o;
  logic       holds_left_o;
  logic       holds_right_o;
  logic       status_o;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   ring_now = 16;
  logic took [16];

  hygienic_fork_arbiter dut (.*);

  fork_grant_checker grant_chk (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .req_type_i,
    .requester_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .phase_i       (phase_o),
    .holds_left_i  (holds_left_o),
    .holds_right_i (holds_right_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(input logic kind, input logic [3:0] who);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    requester_i <= who;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off until every predicted grant has come out.
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_ring(input logic [4:0] size);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ring_now = (size < 5'd2) ? 2 : (size > 5'd16) ? 16 : int'(size);
  endtask

  initial begin
    logic [4:0] ring_plan [12];
    logic       kind;
    logic [3:0] who;
    int         in_ring;
    ring_plan = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd3,
                  5'd17, 5'd9, 5'd1, 5'd16, 5'd7, 5'd12};
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    req_type_i  <= hfa_pkg::REQ_TAKE;
    requester_i <= '0;
    for (int k = 0; k < 16; k++) took[k] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Contention around forks 0..2 and the wrap at the top of the ring.
    send_request(hfa_pkg::REQ_TAKE, 4'd0);     send_request(hfa_pkg::REQ_TAKE, 4'd0);
    send_request(hfa_pkg::REQ_TAKE, 4'd1);     send_request(hfa_pkg::REQ_RELEASE, 4'd1);
    send_request(hfa_pkg::REQ_RELEASE, 4'd0);  send_request(hfa_pkg::REQ_TAKE, 4'd1);
    send_request(hfa_pkg::REQ_RELEASE, 4'd1);  send_request(hfa_pkg::REQ_RELEASE, 4'd1);
    send_request(hfa_pkg::REQ_TAKE, 4'd15);    send_request(hfa_pkg::REQ_TAKE, 4'd14);
    send_request(hfa_pkg::REQ_RELEASE, 4'd15); send_request(hfa_pkg::REQ_TAKE, 4'd14);
    send_request(hfa_pkg::REQ_RELEASE, 4'd14);

    // Undersized ring acts as two seats; higher indexes fall outside it.
    set_ring(5'd0);
    send_request(hfa_pkg::REQ_TAKE, 4'd1);     send_request(hfa_pkg::REQ_TAKE, 4'd0);
    send_request(hfa_pkg::REQ_TAKE, 4'd3);     send_request(hfa_pkg::REQ_TAKE, 4'd15);
    send_request(hfa_pkg::REQ_RELEASE, 4'd1);  send_request(hfa_pkg::REQ_RELEASE, 4'd0);
    send_request(hfa_pkg::REQ_TAKE, 4'd0);     send_request(hfa_pkg::REQ_RELEASE, 4'd0);

    set_ring(5'd31);
    send_request(hfa_pkg::REQ_TAKE, 4'd15);    send_request(hfa_pkg::REQ_RELEASE, 4'd15);
    send_request(hfa_pkg::REQ_RELEASE, 4'd15);

    for (int seg = 0; seg < 12; seg++) begin
      set_ring(ring_plan[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      in_ring = 0;
      while (in_ring < 150) begin
        if ($urandom_range(99) < 8) who = 4'($urandom_range(15));
        else who = 4'($urandom_range(ring_now - 1));
        // Mostly alternate take and release per seat; the rest is noise.
        if ($urandom_range(99) < 80)
          kind = took[who] ? hfa_pkg::REQ_RELEASE : hfa_pkg::REQ_TAKE;
        else kind = 1'($urandom_range(1));
        took[who] = (kind == hfa_pkg::REQ_TAKE);
        send_request(kind, who);
        if (int'(who) < ring_now) in_ring++;
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
src/hfa_pkg.sv
src/hfa_ram.sv
src/hfa_update.sv
src/hygienic_fork_arbiter.sv
verif/fork_grant_checker.sv
verif/tb.sv
